### rtl/core/wttd_pkg.sv
// ----------------------------------------------------------------------------
// wttd_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the window top-two and longest descent block.
// ----------------------------------------------------------------------------
package wttd_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 5;
    localparam logic [POS_W-1:0] LAST_STEP = POS_W'(HIST_DEPTH - 1);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic             accept;    // input transfer this cycle
        logic             step_en;   // one scan step this cycle
        logic             first;     // first scan step
        logic             last;      // last scan step, no neighbor compare
        logic [POS_W-1:0] step;      // index of the entry at tap 0
        logic             load_out;  // move scan results to output register
    } cmd_t;

    // One result item
    typedef struct packed {
        logic                       shifted;
        logic signed [SAMPLE_W-1:0] largest;
        logic [POS_W-1:0]           largest_pos;
        logic signed [SAMPLE_W-1:0] runner_up;
        logic [POS_W-1:0]           run_begin;
        logic [POS_W-1:0]           run_end;
        logic [LEN_W-1:0]           run_length;
    } result_t;

endpackage

### rtl/core/wttd_ctrl.sv
// ----------------------------------------------------------------------------
// wttd_ctrl
// Sequencer: takes one input transfer, steps the datapath through one scan
// of the history, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wttd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output wttd_pkg::cmd_t cmd
);

    wttd_pkg::state_t            state_reg, state_next;
    logic [wttd_pkg::POS_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wttd_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = wttd_pkg::ST_SCAN;
            end
            wttd_pkg::ST_SCAN: begin
                if (step_reg == wttd_pkg::LAST_STEP) state_next = wttd_pkg::ST_WRITE;
            end
            wttd_pkg::ST_WRITE: begin
                if (out_free) state_next = wttd_pkg::ST_IDLE;
            end
            default: state_next = wttd_pkg::ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        s_tready     = (state_reg == wttd_pkg::ST_IDLE);
        cmd.accept   = (state_reg == wttd_pkg::ST_IDLE) && s_tvalid;
        cmd.step_en  = (state_reg == wttd_pkg::ST_SCAN);
        cmd.first    = (step_reg == '0);
        cmd.last     = (step_reg == wttd_pkg::LAST_STEP);
        cmd.step     = step_reg;
        cmd.load_out = (state_reg == wttd_pkg::ST_WRITE) && out_free;
    end

    // Step counter and output valid
    always_comb begin
        step_next = (state_reg == wttd_pkg::ST_SCAN) ? step_reg + 1'b1 : '0;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wttd_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/wttd_dp.sv
// ----------------------------------------------------------------------------
// wttd_dp
// History shift line, previous-sample register and the scan unit. During a
// scan the history rotates one place per cycle so that taps 0 and 1 always
// show the current entry and its neighbor.
// ----------------------------------------------------------------------------
module wttd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wttd_pkg::cmd_t                cmd,
    input  logic [wttd_pkg::SAMPLE_W-1:0] sample,
    output wttd_pkg::result_t             result
);

    localparam int SW = wttd_pkg::SAMPLE_W;
    localparam int PW = wttd_pkg::POS_W;
    localparam int LW = wttd_pkg::LEN_W;

    logic [SW-1:0] hist_reg [wttd_pkg::HIST_DEPTH];
    logic [SW-1:0] prev_reg;
    logic          started_reg;
    logic          do_shift;

    // Scan accumulators
    logic [SW-1:0] best_reg, best_next;
    logic [PW-1:0] best_pos_reg, best_pos_next;
    logic [SW-1:0] second_reg, second_next;
    logic          second_ok_reg, second_ok_next;
    logic [LW-1:0] run_reg, run_next;
    logic [LW-1:0] longest_reg, longest_next;
    logic [PW-1:0] rb_reg, rb_next;
    logic [PW-1:0] re_reg, re_next;
    logic          shifted_reg;
    wttd_pkg::result_t res_reg;

    logic [SW-1:0] tap0, tap1;
    logic [LW-1:0] run_base, longest_base, run_inc, rb_calc;
    logic [PW-1:0] rb_base, re_base;

    assign do_shift = cmd.accept && started_reg && (sample != prev_reg);
    assign tap0     = hist_reg[0];
    assign tap1     = hist_reg[1];

    // History: shift in on a differing sample, rotate during the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wttd_pkg::HIST_DEPTH; i++) hist_reg[i] <= '0;
        end else if (do_shift) begin
            hist_reg[0] <= sample;
            for (int i = 1; i < wttd_pkg::HIST_DEPTH; i++) hist_reg[i] <= hist_reg[i-1];
        end else if (cmd.step_en) begin
            hist_reg[wttd_pkg::HIST_DEPTH-1] <= hist_reg[0];
            for (int i = 0; i < wttd_pkg::HIST_DEPTH - 1; i++) hist_reg[i] <= hist_reg[i+1];
        end
    end

    // Previous sample and start flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            started_reg <= 1'b0;
        end else if (cmd.accept) begin
            prev_reg    <= sample;
            started_reg <= 1'b1;
        end
    end

    // One scan step: top two and run tracking
    always_comb begin
        run_base     = cmd.first ? LW'(1) : run_reg;
        longest_base = cmd.first ? LW'(1) : longest_reg;
        rb_base      = cmd.first ? '0 : rb_reg;
        re_base      = cmd.first ? '0 : re_reg;
        run_inc      = run_base + 1'b1;
        rb_calc      = {1'b0, cmd.step} + LW'(1) - run_base;

        if (cmd.first) begin
            best_next      = tap0;
            best_pos_next  = '0;
            second_next    = second_reg;
            second_ok_next = 1'b0;
        end else if ($signed(tap0) > $signed(best_reg)) begin
            best_next      = tap0;
            best_pos_next  = cmd.step;
            second_next    = best_reg;
            second_ok_next = 1'b1;
        end else begin
            best_next      = best_reg;
            best_pos_next  = best_pos_reg;
            second_ok_next = 1'b1;
            if (!second_ok_reg || ($signed(tap0) > $signed(second_reg))) begin
                second_next = tap0;
            end else begin
                second_next = second_reg;
            end
        end

        run_next     = run_base;
        longest_next = longest_base;
        rb_next      = rb_base;
        re_next      = re_base;
        if (!cmd.last) begin
            if ($signed(tap0) > $signed(tap1)) begin
                run_next = run_inc;
                if (run_inc > longest_base) begin
                    longest_next = run_inc;
                    rb_next      = rb_calc[PW-1:0];
                    re_next      = cmd.step + 1'b1;
                end
            end else begin
                run_next = LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) shifted_reg <= do_shift;
        if (cmd.step_en) begin
            best_reg      <= best_next;
            best_pos_reg  <= best_pos_next;
            second_reg    <= second_next;
            second_ok_reg <= second_ok_next;
            run_reg       <= run_next;
            longest_reg   <= longest_next;
            rb_reg        <= rb_next;
            re_reg        <= re_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            res_reg.shifted     <= shifted_reg;
            res_reg.largest     <= best_reg;
            res_reg.largest_pos <= best_pos_reg;
            res_reg.runner_up   <= second_reg;
            res_reg.run_begin   <= rb_reg;
            res_reg.run_end     <= re_reg;
            res_reg.run_length  <= longest_reg;
        end
    end

    assign result = res_reg;

endmodule

### rtl/core/window_top_two_and_longest_descent.sv
// ----------------------------------------------------------------------------
// window_top_two_and_longest_descent
// Sample history with top-two and longest strictly decreasing run report.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one signed sample per transfer. If it differs from the
//   previous sample (and is not the first since reset) it enters the
//   16-entry history at index 0.
//   m_ channel: one result per input transfer: maximum and its first index,
//   runner-up, and the first longest decreasing run (begin, end, length).
//   After an input transfer the sequencer scans the history (one entry per
//   cycle through the rotating shift line), then loads the output register,
//   which raises m_tvalid. The sequencer takes the sample in its idle state,
//   then scans and writes; it takes no new sample until the write is done.
//   s_tready is high only while the sequencer is idle. The output register
//   lets the next item be taken while a result waits; if m_tready stays low
//   the sequencer holds its finished scan until the register frees.
//   Reset: history, previous sample and start flag clear; no result pending.
// ----------------------------------------------------------------------------
module window_top_two_and_longest_descent (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] largest, [19:16] largest_pos,
                                   // [35:20] runner_up, [39:36] run_begin,
                                   // [43:40] run_end, [48:44] run_length, rest 0
    output logic [0:0]  m_tuser    // [0] shifted
);

    wttd_pkg::cmd_t    cmd;
    wttd_pkg::result_t result;

    wttd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    wttd_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (s_tdata),
        .result  (result)
    );

    // Pack result fields
    assign m_tdata = {7'd0, result.run_length, result.run_end, result.run_begin,
                      result.runner_up, result.largest_pos, result.largest};
    assign m_tuser = result.shifted;

`ifndef SYNTHESIS
    // An accepted sample always starts a scan on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (cmd.step_en && cmd.first && !s_tready))
        else $error("scan did not start after input transfer");

    // Output register is never overwritten while a result is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register loaded over a pending result");

    // The last scan step is followed by the write phase, not another step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step_en && cmd.last) |=> (!cmd.step_en && !s_tready))
        else $error("scan overran the history");
`endif

endmodule
